// ----- rtl/lnsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnsa_pkg
// Shared constants and elaboration-time functions of the LNS adder: Q52
// fixed-point arithmetic used to build the Chebyshev correction table.
// ----------------------------------------------------------------------------
package lnsa_pkg;

    localparam int          FRAC     = 52;
    localparam logic [63:0] ONE_Q    = 64'd1 << FRAC;
    localparam int          BIT_EXT  = 2;
    localparam int          SAT_INT  = 64;
    localparam int          COEF_W   = 64;

    // Q52 product, keep bits FRAC+63..FRAC
    function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[FRAC+63:FRAC];
    endfunction

    // plain unsigned integer quotient, restoring long division
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] rs;
        q  = 64'd0;
        rs = 65'd0;
        if (b == 64'd0)
        begin
            return 64'd0;
        end
        for (int i = 63; i >= 0; i--)
        begin
            rs = {rs[63:0], a[i]};
            q  = q << 1;
            if (rs >= {1'b0, b})
            begin
                rs   = rs - {1'b0, b};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q52 quotient, low 64 bits kept
    function automatic logic [63:0] div_q(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        logic        bt;
        q = 64'd0;
        r = 64'd0;
        if (b == 64'd0)
        begin
            return 64'd0;
        end
        for (int i = 0; i < 64 + FRAC; i++)
        begin
            bt = (i < 64) ? a[63 - i] : 1'b0;
            r  = {r[62:0], bt};
            q  = q << 1;
            if (r >= b)
            begin
                r    = r - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_q(input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] sum;
        term = ONE_Q;
        sum  = ONE_Q;
        for (int n = 1; n < 60 && term != 64'd0; n++)
        begin
            term = udiv(mul_q(term, y), 64'(n));
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] ln1p_q(input logic [63:0] t);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] sum;
        z   = div_q(t, (ONE_Q << 1) + t);
        z2  = mul_q(z, z);
        p   = z;
        sum = 64'd0;
        for (int n = 0; n < 200 && p != 64'd0; n++)
        begin
            sum = sum + udiv(p, 64'(2 * n + 1));
            p   = mul_q(p, z2);
        end
        return sum << 1;
    endfunction

    function automatic logic [63:0] rsqrt2_calc();
        logic [63:0] s;
        logic [63:0] c;
        s = 64'd0;
        for (int i = FRAC - 1; i >= 0; i--)
        begin
            c = s | (64'd1 << i);
            if (mul_q(c, c) <= (ONE_Q >> 1))
            begin
                s = c;
            end
        end
        return s;
    endfunction

    localparam logic [63:0] LN2_Q    = ln1p_q(ONE_Q);
    localparam logic [63:0] RSQRT2_Q = rsqrt2_calc();

    // log2(1 + 2^-x), Q52 in and out
    function automatic logic [63:0] lns_func(input logic [63:0] x);
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] t;
        k = x >> FRAC;
        r = x & (ONE_Q - 64'd1);
        if (k >= 64'd62)
        begin
            return 64'd0;
        end
        t = exp_q(mul_q(ONE_Q - r, LN2_Q)) >> (k + 64'd1);
        if (t == 64'd0)
        begin
            return 64'd0;
        end
        return div_q(ln1p_q(t), LN2_Q);
    endfunction

    function automatic int eff_cut(input int man, input int cut);
        return (cut < 2 || cut > man) ? ((man + 1) >> 1) : cut;
    endfunction

    function automatic logic [63:0] quarter_to_q(input logic [63:0] num4, input int man);
        if ((num4 >> (man + 2)) >= 64'(SAT_INT))
        begin
            return 64'(SAT_INT) << FRAC;
        end
        return num4 << (FRAC - man - 2);
    endfunction

    // {c0, c1} of one segment, each COEF_W bits
    function automatic logic [2*COEF_W-1:0] coefficients(input logic [63:0] a,
                                                          input int man, input int cut);
        logic [63:0] qmin;
        logic [63:0] qmax;
        logic [63:0] bma;
        logic [63:0] bpa;
        logic [63:0] sb;
        logic [63:0] f0;
        logic [63:0] f1;
        logic [63:0] cc0;
        logic [63:0] ncc1;
        logic [63:0] k0;
        logic [63:0] k1;
        logic [63:0] c0;
        logic [63:0] c1;
        int          sh;
        qmin = quarter_to_q(((a << cut) << 2) + 64'd1, man);
        qmax = quarter_to_q(((((a + 64'd1) << cut) - 64'd1) << 2) + 64'd1, man);
        bma  = (qmax - qmin) >> 1;
        bpa  = (qmax + qmin) >> 1;
        sb   = mul_q(RSQRT2_Q, bma);
        f0   = lns_func(bpa - sb);
        f1   = lns_func(bpa + sb);
        cc0  = (f0 + f1) >> 1;
        ncc1 = mul_q(RSQRT2_Q, (f0 >= f1) ? (f0 - f1) : 64'd0);
        k0   = cc0 + ncc1;
        k1   = (bma != 64'd0) ? div_q(ncc1, bma) : 64'd0;
        sh   = FRAC - man - BIT_EXT;
        c0   = (k0 + (64'd1 << (sh - 1))) >> sh;
        c1   = (k1 + (64'd1 << (sh - 1))) >> sh;
        return {c0, c1};
    endfunction

    function automatic logic rounds_to_zero(input logic [63:0] i, input int man, input int cut);
        int          step;
        logic [63:0] v;
        step = man - cut;
        if ((i >> step) >= 64'(SAT_INT))
        begin
            return 1'b1;
        end
        v = lns_func(i << (FRAC - step));
        return ((v + (64'd1 << (FRAC - man - 1))) >> (FRAC - man)) == 64'd0;
    endfunction

    // segment index width: bit length of imax-1, at least one
    function automatic int table_idx_width(input int log_w, input int man, input int cut);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] v;
        int          sh;
        int          len;
        sh = log_w - 1 - cut;
        lo = 64'd0;
        hi = (sh > 0) ? (64'd1 << sh) : 64'd1;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (rounds_to_zero(mid, man, cut))
            begin
                hi = mid;
            end
            else
            begin
                lo = mid + 64'd1;
            end
        end
        v   = (lo != 64'd0) ? (lo - 64'd1) : 64'd0;
        len = 0;
        while (v != 64'd0)
        begin
            len = len + 1;
            v   = v >> 1;
        end
        return (len < 1) ? 1 : len;
    endfunction

endpackage

// ----- rtl/lnsa_coef_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnsa_coef_rom
// Constant table of Chebyshev offset and slope per segment, filled at
// elaboration, read combinationally at one address.
// ----------------------------------------------------------------------------
module lnsa_coef_rom #(
    parameter int MAN_WIDTH = 8,
    parameter int ECUT      = 4,
    parameter int IDX_W     = 8,
    parameter int C0_W      = 12,
    parameter int C1_W      = 11
) (
    input  logic [IDX_W-1:0] idx,
    output logic [C0_W-1:0]  c0,
    output logic [C1_W-1:0]  c1
);

    localparam int DEPTH = 1 << IDX_W;

    logic [C0_W-1:0] c0_tab [DEPTH];
    logic [C1_W-1:0] c1_tab [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        localparam logic [2*lnsa_pkg::COEF_W-1:0] COEF =
            lnsa_pkg::coefficients(64'(g), MAN_WIDTH, ECUT);
        assign c0_tab[g] = COEF[lnsa_pkg::COEF_W +: C0_W];
        assign c1_tab[g] = COEF[0 +: C1_W];
    end

    assign c0 = c0_tab[idx];
    assign c1 = c1_tab[idx];

endmodule

// ----- rtl/lnsa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnsa_datapath
// Single-pass LNS add: operand clearing, max and difference, interpolated
// correction and wrapped sum.
// ----------------------------------------------------------------------------
module lnsa_datapath #(
    parameter int LOG_WIDTH = 17,
    parameter int MAN_WIDTH = 8,
    parameter int ECUT      = 4,
    parameter int IDX_W     = 8,
    parameter int C0_W      = 12,
    parameter int C1_W      = 11
) (
    input  logic [LOG_WIDTH-1:0] log_x,
    input  logic [LOG_WIDTH-1:0] log_y,
    output logic [LOG_WIDTH-1:0] log_sum
);

    localparam int MAG_W  = LOG_WIDTH - 1;
    localparam int TBL_W  = ECUT + IDX_W;
    localparam int PROD_W = C1_W + ECUT;

    logic             nx;
    logic             ny;
    logic             sz;
    logic [MAG_W-1:0] xm;
    logic [MAG_W-1:0] ym;
    logic [MAG_W:0]   yx;
    logic [MAG_W-1:0] xy;
    logic [MAG_W-1:0] x2;
    logic [MAG_W-1:0] d0;
    logic [TBL_W-1:0] low;
    logic             high_nz;
    logic [IDX_W-1:0] seg;
    logic [ECUT-1:0]  dx;
    logic [C0_W-1:0]  c0;
    logic [C1_W-1:0]  c1;
    logic [PROD_W-1:0] prod;
    logic [C0_W-1:0]  sub;
    logic [C0_W-1:0]  diff;
    logic [MAN_WIDTH-1:0] f;
    logic [MAN_WIDTH:0]   corr;

    assign nx = log_x[MAG_W-1];
    assign ny = log_y[MAG_W-1];
    assign sz = nx ? log_x[MAG_W] : (ny ? log_y[MAG_W] : 1'b0);
    assign xm = nx ? log_x[MAG_W-1:0] : '0;
    assign ym = ny ? log_y[MAG_W-1:0] : '0;

    // borrow out of y - x picks x as the larger
    assign yx = {1'b0, ym} - {1'b0, xm};
    assign xy = xm - ym;
    assign x2 = yx[MAG_W] ? xm : ym;
    assign d0 = yx[MAG_W] ? xy : yx[MAG_W-1:0];

    assign low = d0[TBL_W-1:0];
    if (TBL_W < MAG_W)
    begin : g_high
        assign high_nz = |d0[MAG_W-1:TBL_W];
    end
    else
    begin : g_no_high
        assign high_nz = 1'b0;
    end

    assign seg = low[TBL_W-1:ECUT];
    assign dx  = low[ECUT-1:0];

    lnsa_coef_rom #(
        .MAN_WIDTH (MAN_WIDTH),
        .ECUT      (ECUT),
        .IDX_W     (IDX_W),
        .C0_W      (C0_W),
        .C1_W      (C1_W)
    ) u_rom (
        .idx (seg),
        .c0  (c0),
        .c1  (c1)
    );

    assign prod = PROD_W'(c1) * PROD_W'(dx);
    assign sub  = C0_W'(prod[PROD_W-1:MAN_WIDTH]);
    assign diff = c0 - sub;
    assign f    = (c0 < sub) ? '0 : diff[lnsa_pkg::BIT_EXT +: MAN_WIDTH];

    always_comb
    begin
        if (high_nz)
        begin
            corr = '0;
        end
        else if (low == '0)
        begin
            corr = (MAN_WIDTH + 1)'(1) << MAN_WIDTH;
        end
        else
        begin
            corr = {1'b0, f};
        end
    end

    assign log_sum = {sz, x2 + MAG_W'(corr)};

endmodule

// ----- rtl/lns_adder_interpolated_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_adder_interpolated_core
// Same-sign adder for log-number-system values with a Chebyshev
// linear-interpolation correction table.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                      Handshake
//  --------  -------------------------  ----------------------------------
//  operand   log_x, log_y               beat taken when start & !busy
//  result    log_sum                    beat shown for one cycle with done
//
//  One beat per clock, sustained. The operand register captures at the
//  accepting edge, then the result register loads from it, and done
//  rises together with the new log_sum.
//  busy never rises; all arithmetic sits between the two registers.
//  Reset clears the valid pipe only; payload registers are not reset.
//  The result side cannot stall: each result is shown for exactly one cycle.
//
module lns_adder_interpolated_core #(
    parameter int LOG_WIDTH = 17,
    parameter int MAN_WIDTH = 8,
    parameter int CUT_WIDTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [LOG_WIDTH-1:0] log_x,
    input  logic [LOG_WIDTH-1:0] log_y,
    output logic                 done,
    output logic [LOG_WIDTH-1:0] log_sum
);

    // effective segment width and table index width, built the same way as
    // the table contents
    localparam int ECUT  = lnsa_pkg::eff_cut(MAN_WIDTH, CUT_WIDTH);
    localparam int IDX_W = lnsa_pkg::table_idx_width(LOG_WIDTH, MAN_WIDTH, ECUT);
    localparam int C0_W  = MAN_WIDTH + 4;
    localparam int C1_W  = MAN_WIDTH + 3;

    logic [LOG_WIDTH-1:0] x_reg;
    logic [LOG_WIDTH-1:0] y_reg;
    logic                 in_valid_reg;
    logic [LOG_WIDTH-1:0] sum_reg;
    logic [LOG_WIDTH-1:0] sum_next;
    logic                 done_reg;

    // never hold off the source
    assign busy = 1'b0;

    // valid pipe: advance every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    // operand register: capture on an accepted beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= log_x;
            y_reg <= log_y;
        end
    end

    // all arithmetic sits between the two registers
    lnsa_datapath #(
        .LOG_WIDTH (LOG_WIDTH),
        .MAN_WIDTH (MAN_WIDTH),
        .ECUT      (ECUT),
        .IDX_W     (IDX_W),
        .C0_W      (C0_W),
        .C1_W      (C1_W)
    ) u_datapath (
        .log_x   (x_reg),
        .log_y   (y_reg),
        .log_sum (sum_next)
    );

    // result register: load only when a beat is in flight
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign done    = done_reg;
    assign log_sum = sum_reg;

endmodule
